// ----- rtl/exptok_pkg.sv -----
// Shared types, character codes and result codes for the expression tokenizer.
`timescale 1ns / 1ps

package exptok_pkg;

    // Result kinds
    localparam logic [1:0] KIND_VALUE = 2'd0;
    localparam logic [1:0] KIND_TOKEN = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;
    localparam logic [1:0] KIND_END   = 2'd3;

    // Token types
    localparam logic [3:0] TT_IDENT  = 4'd0;
    localparam logic [3:0] TT_INT    = 4'd1;
    localparam logic [3:0] TT_FLOAT  = 4'd2;
    localparam logic [3:0] TT_STRING = 4'd3;
    localparam logic [3:0] TT_ADD    = 4'd4;
    localparam logic [3:0] TT_SUB    = 4'd5;
    localparam logic [3:0] TT_MUL    = 4'd6;
    localparam logic [3:0] TT_DIV    = 4'd7;
    localparam logic [3:0] TT_MOD    = 4'd8;
    localparam logic [3:0] TT_POW    = 4'd9;
    localparam logic [3:0] TT_LPAR   = 4'd10;
    localparam logic [3:0] TT_RPAR   = 4'd11;
    localparam logic [3:0] TT_ASSIGN = 4'd12;

    // Error codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_ILLEGAL = 2'd1;
    localparam logic [1:0] ERR_DOT     = 2'd2;

    // Character codes
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_Z   = 8'h7A;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_Z   = 8'h5A;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_LPAR   = 8'h28;
    localparam logic [7:0] CH_RPAR   = 8'h29;
    localparam logic [7:0] CH_EQ     = 8'h3D;

    localparam logic [19:0] LINE_MAX = 20'hFFFFF;
    localparam logic [15:0] COL_MAX  = 16'hFFFF;

    // Most results one byte can cause
    localparam int MAX_RES = 4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  token_type;
        logic [7:0]  value_char;
        logic [19:0] line;
        logic [15:0] column;
        logic [15:0] length;
        logic [1:0]  error_code;
    } exptok_result_t;

    // All results of one byte; last_idx is the index of the final one
    typedef struct packed {
        logic [1:0]                    last_idx;
        exptok_result_t [MAX_RES-1:0]  res;
    } exptok_bundle_t;

    typedef struct packed {
        logic           valid;
        exptok_bundle_t bundle;
    } exptok_qhead_t;

    function automatic exptok_result_t mk_res(
        input logic [1:0]  kind,
        input logic [3:0]  ttype,
        input logic [7:0]  vch,
        input logic [19:0] line,
        input logic [15:0] col,
        input logic [15:0] len,
        input logic [1:0]  err
    );
        exptok_result_t r;
        r.kind       = kind;
        r.token_type = ttype;
        r.value_char = vch;
        r.line       = line;
        r.column     = col;
        r.length     = len;
        r.error_code = err;
        return r;
    endfunction

endpackage

// ----- rtl/exptok_front.sv -----
// Byte classifier and lexer state: turns one source byte into a bundle of results.
`timescale 1ns / 1ps

module exptok_front #(
    parameter int MAX_TOKEN_LENGTH = 65535
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  logic [7:0]                ch,
    input  logic                      last_byte,
    output logic                      push,
    output exptok_pkg::exptok_bundle_t bundle
);
    import exptok_pkg::*;

    localparam logic [15:0] LEN_CAP =
        (MAX_TOKEN_LENGTH > 65535) ? 16'hFFFF : 16'(MAX_TOKEN_LENGTH);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_NUMBER,
        MODE_STRING
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic        dot_reg, dot_next;
    logic [15:0] vlen_reg, vlen_next;
    logic [19:0] tline_reg, tline_next;
    logic [15:0] tcol_reg, tcol_next;
    logic [19:0] cline_reg, cline_next;
    logic [15:0] ccol_reg, ccol_next;
    logic        halted_reg, halted_next;

    exptok_result_t [MAX_RES-1:0] res;
    logic [2:0]                   n_res;

    function automatic logic [3:0] cur_type(input mode_t m, input logic d);
        logic [3:0] t;
        priority if (m == MODE_IDENT)
            t = TT_IDENT;
        else if (m == MODE_NUMBER)
            t = d ? TT_FLOAT : TT_INT;
        else
            t = TT_STRING;
        return t;
    endfunction

    logic is_letter, is_numch, is_quote, is_sep, is_op;
    logic [3:0] op_type;

    always_comb
    begin
        is_letter = (ch >= CH_LC_A && ch <= CH_LC_Z) || (ch >= CH_UC_A && ch <= CH_UC_Z)
                    || ch == CH_UNDER;
        is_numch  = (ch >= CH_ZERO && ch <= CH_NINE) || ch == CH_DOT;
        is_quote  = ch == CH_DQUOTE || ch == CH_SQUOTE;
        is_sep    = ch == CH_SPACE || ch == CH_TAB || ch == CH_NL;
        is_op     = 1'b1;
        op_type   = TT_ADD;
        unique case (ch)
            CH_PLUS:  op_type = TT_ADD;
            CH_MINUS: op_type = TT_SUB;
            CH_STAR:  op_type = TT_MUL;
            CH_SLASH: op_type = TT_DIV;
            CH_PCT:   op_type = TT_MOD;
            CH_CARET: op_type = TT_POW;
            CH_LPAR:  op_type = TT_LPAR;
            CH_RPAR:  op_type = TT_RPAR;
            CH_EQ:    op_type = TT_ASSIGN;
            default:  is_op = 1'b0;
        endcase
    end

    always_comb
    begin
        logic done;
        logic add;
        logic num;

        mode_next   = mode_reg;
        dot_next    = dot_reg;
        vlen_next   = vlen_reg;
        tline_next  = tline_reg;
        tcol_next   = tcol_reg;
        cline_next  = cline_reg;
        ccol_next   = ccol_reg;
        halted_next = halted_reg;
        res         = '0;
        n_res       = 3'd0;
        done        = 1'b0;
        add         = 1'b0;
        num         = 1'b0;

        if (!halted_reg)
        begin
            // continue or close the open token
            unique case (mode_reg)
                MODE_IDENT:
                begin
                    if (is_letter)
                    begin
                        add  = 1'b1;
                        done = 1'b1;
                    end
                end
                MODE_NUMBER:
                begin
                    if (is_numch)
                    begin
                        num  = 1'b1;
                        done = 1'b1;
                    end
                end
                MODE_STRING:
                begin
                    if (!is_quote)
                        add = 1'b1;
                    done = 1'b1;
                end
                default: ;
            endcase

            if (mode_reg != MODE_IDLE && !add && !num)
            begin
                res[n_res[1:0]] = mk_res(KIND_TOKEN, cur_type(mode_reg, dot_reg), 8'd0,
                                         tline_reg, tcol_reg, vlen_reg, ERR_NONE);
                n_res     = n_res + 3'd1;
                mode_next = MODE_IDLE;
                dot_next  = 1'b0;
                vlen_next = '0;
            end

            // fresh byte
            if (!done)
            begin
                priority if (is_sep)
                begin
                end
                else if (is_letter || is_numch || is_quote)
                begin
                    mode_next  = is_letter ? MODE_IDENT :
                                 is_numch  ? MODE_NUMBER : MODE_STRING;
                    dot_next   = 1'b0;
                    vlen_next  = '0;
                    tline_next = cline_reg;
                    tcol_next  = ccol_reg;
                    add        = is_letter;
                    num        = is_numch;
                end
                else if (is_op)
                begin
                    res[n_res[1:0]] = mk_res(KIND_TOKEN, op_type, 8'd0, cline_reg, ccol_reg,
                                             16'd0, ERR_NONE);
                    n_res = n_res + 3'd1;
                end
                else
                begin
                    res[n_res[1:0]] = mk_res(KIND_ERROR, 4'd0, 8'd0, cline_reg, ccol_reg,
                                             16'd0, ERR_ILLEGAL);
                    n_res       = n_res + 3'd1;
                    halted_next = 1'b1;
                    mode_next   = MODE_IDLE;
                end
            end

            // number byte: drop leading zeros, catch a second dot
            if (num)
            begin
                priority if (ch == CH_ZERO && vlen_next == 16'd0)
                begin
                end
                else if (ch == CH_DOT && dot_next)
                begin
                    res[n_res[1:0]] = mk_res(KIND_ERROR, 4'd0, 8'd0, cline_reg, ccol_reg,
                                             16'd0, ERR_DOT);
                    n_res       = n_res + 3'd1;
                    halted_next = 1'b1;
                    mode_next   = MODE_IDLE;
                end
                else
                begin
                    if (ch == CH_DOT)
                        dot_next = 1'b1;
                    add = 1'b1;
                end
            end

            if (add)
            begin
                if (vlen_next < LEN_CAP)
                    vlen_next = vlen_next + 16'd1;
                res[n_res[1:0]] = mk_res(KIND_VALUE, cur_type(mode_next, dot_next), ch,
                                         tline_next, tcol_next, vlen_next, ERR_NONE);
                n_res = n_res + 3'd1;
            end
        end

        if (last_byte)
        begin
            if (!halted_next && mode_next != MODE_IDLE)
            begin
                res[n_res[1:0]] = mk_res(KIND_TOKEN, cur_type(mode_next, dot_next), 8'd0,
                                         tline_next, tcol_next, vlen_next, ERR_NONE);
                n_res = n_res + 3'd1;
            end
            res[n_res[1:0]] = mk_res(KIND_END, 4'd0, 8'd0, cline_reg, ccol_reg, 16'd0,
                                     ERR_NONE);
            n_res       = n_res + 3'd1;
            mode_next   = MODE_IDLE;
            dot_next    = 1'b0;
            vlen_next   = '0;
            tline_next  = 20'd1;
            tcol_next   = '0;
            cline_next  = 20'd1;
            ccol_next   = '0;
            halted_next = 1'b0;
        end
        else if (!halted_next)
        begin
            if (ch == CH_NL)
            begin
                if (cline_reg < LINE_MAX)
                    cline_next = cline_reg + 20'd1;
                ccol_next = '0;
            end
            else if (ccol_reg < COL_MAX)
                ccol_next = ccol_reg + 16'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            dot_reg    <= 1'b0;
            vlen_reg   <= '0;
            tline_reg  <= 20'd1;
            tcol_reg   <= '0;
            cline_reg  <= 20'd1;
            ccol_reg   <= '0;
            halted_reg <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            dot_reg    <= dot_next;
            vlen_reg   <= vlen_next;
            tline_reg  <= tline_next;
            tcol_reg   <= tcol_next;
            cline_reg  <= cline_next;
            ccol_reg   <= ccol_next;
            halted_reg <= halted_next;
        end
    end

    // a halted byte with no end of text gives nothing to queue
    assign push            = accept && (n_res != 3'd0);
    assign bundle.res      = res;
    assign bundle.last_idx = 2'(n_res - 3'd1);

endmodule

// ----- rtl/exptok_queue.sv -----
// Short register queue of result bundles between the front and back ends.
`timescale 1ns / 1ps

module exptok_queue #(
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  exptok_pkg::exptok_bundle_t wr_bundle,
    input  logic                       pop,
    output exptok_pkg::exptok_qhead_t  head,
    output logic                       full
);
    import exptok_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    exptok_bundle_t store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            store_reg[wr_ptr_reg] <= wr_bundle;
    end

    assign head.valid  = (count_reg != '0);
    assign head.bundle = store_reg[rd_ptr_reg];
    assign full        = (count_reg == CNT_W'(DEPTH));

endmodule

// ----- rtl/exptok_back.sv -----
// Result sequencer: hands out the results of the head bundle one per request.
`timescale 1ns / 1ps

module exptok_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  exptok_pkg::exptok_qhead_t head,
    output logic                      pop,
    output logic                      tok_valid,
    input  logic                      tok_stall,
    output logic [1:0]                kind,
    output logic [3:0]                token_type,
    output logic [7:0]                value_char,
    output logic [19:0]               line,
    output logic [15:0]               column,
    output logic [15:0]               length,
    output logic [1:0]                error_code,
    output logic                      is_last
);
    import exptok_pkg::*;

    logic [1:0]     idx_reg, idx_next;
    logic           take;
    exptok_result_t cur;

    assign cur       = head.bundle.res[idx_reg];
    assign tok_valid = head.valid;
    assign is_last   = (idx_reg == head.bundle.last_idx);
    assign take      = tok_valid && !tok_stall;
    assign pop       = take && is_last;

    always_comb
    begin
        idx_next = idx_reg;
        if (take)
            idx_next = is_last ? 2'd0 : idx_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= 2'd0;
        else
            idx_reg <= idx_next;
    end

    assign kind       = cur.kind;
    assign token_type = cur.token_type;
    assign value_char = cur.value_char;
    assign line       = cur.line;
    assign column     = cur.column;
    assign length     = cur.length;
    assign error_code = cur.error_code;

endmodule

// ----- rtl/expression_tokenizer.sv -----
// Top level of the streaming expression tokenizer.
//
//  channel | handshake              | payload
//  --------+------------------------+-------------------------------------------
//  byte    | byte_valid, byte_stall | ch, last_byte
//  tok     | tok_valid, tok_stall   | kind, token_type, value_char, line,
//          |                        | column, length, error_code, is_last
//
// One source byte is classified and the lexer state updated in the cycle it is
// accepted; its 0 to 4 results go as one bundle into a QUEUE_DEPTH register queue,
// and the first shows at the output once that bundle is at the queue head. The
// result port gives one result per cycle while tok_stall is low, in order; bytes
// with no result push nothing. byte_stall is high only while the queue is full.
// Reset (rst_n low, async) returns to line 1 column 0 with an empty queue.
`timescale 1ns / 1ps

module expression_tokenizer #(
    parameter int MAX_TOKEN_LENGTH = 65535,
    parameter int QUEUE_DEPTH      = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  ch,
    input  logic        last_byte,
    output logic        tok_valid,
    input  logic        tok_stall,
    output logic [1:0]  kind,
    output logic [3:0]  token_type,
    output logic [7:0]  value_char,
    output logic [19:0] line,
    output logic [15:0] column,
    output logic [15:0] length,
    output logic [1:0]  error_code,
    output logic        is_last
);
    import exptok_pkg::*;

    logic           accept;
    logic           push;
    logic           pop;
    logic           full;
    exptok_bundle_t bundle;
    exptok_qhead_t  head;

    assign byte_stall = full;
    assign accept     = byte_valid && !full;

    exptok_front #(
        .MAX_TOKEN_LENGTH(MAX_TOKEN_LENGTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .ch        (ch),
        .last_byte (last_byte),
        .push      (push),
        .bundle    (bundle)
    );

    exptok_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_bundle (bundle),
        .pop       (pop),
        .head      (head),
        .full      (full)
    );

    exptok_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .pop        (pop),
        .tok_valid  (tok_valid),
        .tok_stall  (tok_stall),
        .kind       (kind),
        .token_type (token_type),
        .value_char (value_char),
        .line       (line),
        .column     (column),
        .length     (length),
        .error_code (error_code),
        .is_last    (is_last)
    );

    // end of input always closes out its byte
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_valid && kind == KIND_END) |-> is_last)
        else $error("end-of-input result not marked last");

    // an error code appears exactly on error results
    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid |-> ((kind == KIND_ERROR) == (error_code != ERR_NONE)))
        else $error("error code mismatch with result kind");

    // input is held off only while results are waiting
    a_stall_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> tok_valid)
        else $error("input stalled with empty queue");

endmodule
